/* rtl/rlss_pkg.sv */
// Shared types and constants for the RGB LED strip serializer.
// No dependencies; imported by every module of the block.
package rlss_pkg;

  // Field widths fixed by the item format
  localparam int unsigned TickW     = 16;
  localparam int unsigned ResetW    = 10;
  localparam int unsigned CountW    = 7;
  localparam int unsigned IndexW    = 6;
  localparam int unsigned ColorW    = 24;
  localparam int unsigned BitPosW   = 5;
  localparam int unsigned BitsPerLed = 24;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned InDataW   = 32;
  localparam int unsigned OutDataW  = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PERIOD_LAST = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ONE_HIGH    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ZERO_HIGH   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_RESET_PER   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LSB_FIRST   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_LED_COUNT   = 3'd5;

  // Opcodes of an input item
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_START = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  // Classified item handed from front to back
  typedef struct packed {
    cmd_e              kind;
    logic              wr_ok;
    logic [IndexW-1:0] led_index;
    logic [ColorW-1:0] color;     // red, green, blue from high to low
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_LEAD  = 4'b0010,
    PH_DATA  = 4'b0100,
    PH_TRAIL = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [TickW-1:0]  period_last;
    logic [TickW-1:0]  one_high;
    logic [TickW-1:0]  zero_high;
    logic [ResetW-1:0] reset_periods;
    logic              lsb_first;
    logic [CountW-1:0] led_count;
  } cfg_t;

  typedef struct packed {
    logic frame_done;
    logic accepted;
    logic busy;
    logic line_level;
  } result_t;

endpackage

/* rtl/rlss_front.sv */
// Front end: takes input items, decodes the opcode and checks write range.
// Depends on rlss_pkg.
module rlss_front import rlss_pkg::*; #(
  parameter int MAX_LEDS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [InDataW-1:0] in_data_i,
  input  logic [CountW-1:0]  led_count_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output cmd_t               cmd_o
);

  logic        valid_q, valid_d;
  cmd_t        cmd_q, cmd_d;
  logic [1:0]  op;
  logic [IndexW-1:0] idx;
  logic        take;

  assign op   = in_data_i[1:0];
  assign idx  = in_data_i[7:2];
  assign in_ready_o = !valid_q || cmd_ready_i;
  assign take = in_valid_i && in_ready_o;

  // Classify the item
  always_comb begin
    cmd_d.led_index = idx;
    cmd_d.color     = {in_data_i[15:8], in_data_i[23:16], in_data_i[31:24]};
    cmd_d.wr_ok     = ({1'b0, idx} < led_count_i) && (32'(idx) < MAX_LEDS);
    unique case (op)
      OP_TICK:  cmd_d.kind = CMD_TICK;
      OP_WRITE: cmd_d.kind = CMD_WRITE;
      OP_START: cmd_d.kind = CMD_START;
      default:  cmd_d.kind = CMD_NOP;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

/* rtl/rlss_queue.sv */
// Two-entry queue of classified items between front and back end.
// Depends on rlss_pkg.
module rlss_queue import rlss_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_cmd_o = entry_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

/* rtl/rlss_back.sv */
// Back end: colour store, frame sequencer, bit timing and result register.
// Depends on rlss_pkg.
module rlss_back import rlss_pkg::*; #(
  parameter int MAX_LEDS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  cmd_t                cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o
);

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  phase_e             phase_q, phase_d;
  logic [CountW-1:0]  led_q, led_d;
  logic [BitPosW-1:0] bit_q, bit_d;
  logic [TickW-1:0]   tick_q, tick_d;
  logic [ResetW-1:0]  rcnt_q, rcnt_d;
  logic               ovalid_q, ovalid_d;
  result_t            res_q, res_d;
  logic               exec;

  // Colour store and current-LED read port
  logic [ColorW-1:0]  mem_q [MAX_LEDS];
  logic               vld_q [MAX_LEDS];
  logic [ColorW-1:0]  rd_data_q, fwd_data_q;
  logic               rd_ok_q, fwd_q;
  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic               rd_in_range;
  logic [ColorW-1:0]  color;

  // Bit timing helpers
  logic [TickW-1:0]   duty;
  logic [7:0]         bytev;
  logic [2:0]         bitn;
  logic               period_end;
  logic               rdone;
  logic [CountW:0]    next_led;
  logic               last_led;

  assign cmd_ready_o = !ovalid_q || out_ready_i;
  assign exec        = cmd_valid_i && cmd_ready_o;

  assign waddr       = AW'(cmd_i.led_index);
  assign raddr       = AW'(led_d);
  assign rd_in_range = 32'(led_d) < MAX_LEDS;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= cmd_i.color;
    end
    rd_data_q  <= mem_q[raddr];
    fwd_data_q <= cmd_i.color;
  end

  // Valid bits make unwritten entries read as zero after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_LEDS; i++) begin
        vld_q[i] <= 1'b0;
      end
      rd_ok_q <= 1'b0;
      fwd_q   <= 1'b0;
    end else begin
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      rd_ok_q <= rd_in_range && vld_q[raddr];
      fwd_q   <= we && rd_in_range && (waddr == raddr);
    end
  end

  assign color = fwd_q ? fwd_data_q : (rd_ok_q ? rd_data_q : '0);

  // Duty of the current bit period
  always_comb begin
    bitn = cfg_i.lsb_first ? bit_q[2:0] : ~bit_q[2:0];
    case (bit_q[4:3])
      2'd0:    bytev = color[15:8];
      2'd1:    bytev = color[23:16];
      default: bytev = color[7:0];
    endcase
    unique case (phase_q)
      PH_LEAD: duty = (rcnt_q == '0) ? (cfg_i.period_last >> 1) : '0;
      PH_DATA: duty = bytev[bitn] ? cfg_i.one_high : cfg_i.zero_high;
      default: duty = '0;
    endcase
  end

  assign period_end = tick_q >= cfg_i.period_last;
  assign rdone      = ({1'b0, rcnt_q} + 11'd1) >= {1'b0, cfg_i.reset_periods};
  assign next_led   = {1'b0, led_q} + 8'd1;
  assign last_led   = (next_led >= {1'b0, cfg_i.led_count}) || (32'(next_led) >= MAX_LEDS);

  // Sequencer
  always_comb begin
    phase_d = phase_q;
    led_d   = led_q;
    bit_d   = bit_q;
    tick_d  = tick_q;
    rcnt_d  = rcnt_q;
    we      = 1'b0;
    res_d   = '0;
    if (exec) begin
      case (cmd_i.kind)
        CMD_TICK: begin
          if (phase_q != PH_IDLE) begin
            res_d.line_level = tick_q < duty;
            if (period_end) begin
              tick_d = '0;
              unique case (phase_q)
                PH_LEAD: begin
                  if (rdone) begin
                    rcnt_d  = '0;
                    led_d   = '0;
                    bit_d   = '0;
                    phase_d = (cfg_i.led_count == '0) ? PH_TRAIL : PH_DATA;
                  end else begin
                    rcnt_d = rcnt_q + 1'b1;
                  end
                end
                PH_DATA: begin
                  if ((6'(bit_q) + 6'd1) >= 6'(BitsPerLed)) begin
                    bit_d = '0;
                    led_d = CountW'(next_led);
                    if (last_led) begin
                      rcnt_d  = '0;
                      phase_d = PH_TRAIL;
                    end
                  end else begin
                    bit_d = bit_q + 1'b1;
                  end
                end
                PH_TRAIL: begin
                  if (rdone) begin
                    rcnt_d           = '0;
                    phase_d          = PH_IDLE;
                    res_d.frame_done = 1'b1;
                  end else begin
                    rcnt_d = rcnt_q + 1'b1;
                  end
                end
                default: ;
              endcase
            end else begin
              tick_d = tick_q + 16'd1;
            end
          end
        end
        CMD_WRITE: begin
          if (cmd_i.wr_ok) begin
            we             = 1'b1;
            res_d.accepted = 1'b1;
          end
        end
        CMD_START: begin
          if (phase_q == PH_IDLE) begin
            phase_d        = PH_LEAD;
            led_d          = '0;
            bit_d          = '0;
            tick_d         = '0;
            rcnt_d         = '0;
            res_d.accepted = 1'b1;
          end
        end
        default: ;
      endcase
      res_d.busy = (phase_d != PH_IDLE);
    end
  end

  // Result register parts the back end from the receiver
  always_comb begin
    ovalid_d = ovalid_q;
    if (cmd_ready_o) begin
      ovalid_d = exec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      led_q    <= '0;
      bit_q    <= '0;
      tick_q   <= '0;
      rcnt_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      led_q    <= led_d;
      bit_q    <= bit_d;
      tick_q   <= tick_d;
      rcnt_q   <= rcnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = {4'b0000, res_q};

endmodule

/* rtl/rgb_led_strip_serializer_unit.sv */
// Top level of the RGB LED strip serializer: configuration registers,
// front end, item queue and back end. Depends on rlss_pkg and submodules.
//
// Usage: the input stream carries one item per transfer: a tick advances
// the line timing by one tick, a write stores one LED colour, a start
// begins a frame. Every item gives exactly one result item on the output
// stream with the line level for that tick, the busy flag, an accepted
// flag and a frame-done pulse.
// Path: a taken item passes the front register, a queue entry and the result
// register before its result is presented. Throughput is one item per cycle
// while the receiver takes every result; the sequencer updates its state once
// per item in the back end.
// The configuration port writes a register whenever cfg_we_i is high; the user
// must write it only while no items are in flight, as the block does not enforce it.
// Reset clears the frame state, the queue and the per-LED valid bits, so
// every colour reads as zero until written; no clearing pass is needed.
// When the receiver stalls, the result register holds, the queue fills and
// s_axis_tready falls after at most four further items.
module rgb_led_strip_serializer_unit import rlss_pkg::*; #(
  parameter int MAX_LEDS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // op[1:0], led_index[7:2], red[15:8], green[23:16], blue[31:24]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // line_level[0], busy_res[1], accepted[2], frame_done[3], zero[7:4]
  output logic [OutDataW-1:0] m_axis_tdata
);

  cfg_t cfg_q;
  logic fr_valid, fr_ready;
  cmd_t fr_cmd;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period_last   <= 16'd104;
      cfg_q.one_high      <= 16'd69;
      cfg_q.zero_high     <= 16'd34;
      cfg_q.reset_periods <= 10'd40;
      cfg_q.lsb_first     <= 1'b1;
      cfg_q.led_count     <= 7'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PERIOD_LAST: cfg_q.period_last   <= cfg_wdata_i;
        CFG_ONE_HIGH:    cfg_q.one_high      <= cfg_wdata_i;
        CFG_ZERO_HIGH:   cfg_q.zero_high     <= cfg_wdata_i;
        CFG_RESET_PER:   cfg_q.reset_periods <= cfg_wdata_i[ResetW-1:0];
        CFG_LSB_FIRST:   cfg_q.lsb_first     <= cfg_wdata_i[0];
        CFG_LED_COUNT:   cfg_q.led_count     <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  rlss_front #(
    .MAX_LEDS (MAX_LEDS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .led_count_i (cfg_q.led_count),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .cmd_o       (fr_cmd)
  );

  rlss_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_cmd_i   (fr_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_cmd_o    (q_cmd)
  );

  rlss_back #(
    .MAX_LEDS (MAX_LEDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for rgb_led_strip_serializer_unit: streams tick, colour
// write and start items, predicts every result item and compares it field by field.
// Depends on rlss_pkg and the RTL of the block only.
module tb_top import rlss_pkg::*; ();

  localparam int MaxLeds    = 64;
  localparam int NumPhases  = 10;
  localparam int CycleLimit = 400000;
  localparam int MaxReports = 20;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // op[1:0], led_index[7:2], red[15:8], green[23:16], blue[31:24]
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // line_level[0], busy_res[1], accepted[2], frame_done[3], zero[7:4]
  logic [OutDataW-1:0] m_axis_tdata;

  bit idle_on     = 1'b0;
  int hold_cycles = 0;
  int cycles      = 0;
  int settings    = 0;

  rgb_led_strip_serializer_unit #(
    .MAX_LEDS(MaxLeds)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Line predictor and result scoreboard
  class strip_scoreboard;
    logic [ColorW-1:0]  colours [MaxLeds];
    phase_e             ph;
    logic [CountW-1:0]  led_pos;
    logic [BitPosW-1:0] bit_pos;
    logic [TickW-1:0]   tick_cnt;
    logic [ResetW-1:0]  reset_cnt;
    cfg_t               cfg;
    result_t            pending_results [$];
    int errors, checked, frames, writes_stored, starts_taken;

    function new();
      foreach (colours[i]) colours[i] = '0;
      ph        = PH_IDLE;
      led_pos   = '0;
      bit_pos   = '0;
      tick_cnt  = '0;
      reset_cnt = '0;
      cfg.period_last   = 16'd104;
      cfg.one_high      = 16'd69;
      cfg.zero_high     = 16'd34;
      cfg.reset_periods = 10'd40;
      cfg.lsb_first     = 1'b1;
      cfg.led_count     = 7'd4;
      errors = 0; checked = 0; frames = 0; writes_stored = 0; starts_taken = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] v);
      case (idx)
        CFG_PERIOD_LAST: cfg.period_last   = v;
        CFG_ONE_HIGH:    cfg.one_high      = v;
        CFG_ZERO_HIGH:   cfg.zero_high     = v;
        CFG_RESET_PER:   cfg.reset_periods = v[ResetW-1:0];
        CFG_LSB_FIRST:   cfg.lsb_first     = v[0];
        CFG_LED_COUNT:   cfg.led_count     = v[CountW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_count();
      return (cfg.led_count < MaxLeds) ? int'(cfg.led_count) : MaxLeds;
    endfunction

    function bit section_done();
      return int'(reset_cnt) + 1 >= int'(cfg.reset_periods);
    endfunction

    // High time of the current bit period
    function logic [TickW-1:0] duty_now();
      logic [ColorW-1:0] c;
      logic [7:0]        byte_v;
      logic [2:0]        bn;
      if (ph == PH_LEAD) return (reset_cnt == 0) ? (cfg.period_last >> 1) : '0;
      if (ph != PH_DATA) return '0;
      c  = (led_pos < MaxLeds) ? colours[led_pos] : '0;
      bn = cfg.lsb_first ? bit_pos[2:0] : 3'd7 - bit_pos[2:0];
      case (bit_pos[4:3])
        2'd0:    byte_v = c[15:8];   // green
        2'd1:    byte_v = c[23:16];  // red
        default: byte_v = c[7:0];    // blue
      endcase
      return byte_v[bn] ? cfg.one_high : cfg.zero_high;
    endfunction

    // Advance the line state by one accepted item and queue its result
    function void take_item(logic [InDataW-1:0] d);
      cmd_e              kind;
      logic [IndexW-1:0] idx;
      result_t           r;
      kind = cmd_e'(d[1:0]);
      idx  = d[7:2];
      r    = '0;
      case (kind)
        CMD_TICK: if (ph != PH_IDLE) begin
          r.line_level = (tick_cnt < duty_now());
          if (tick_cnt >= cfg.period_last) begin
            tick_cnt = '0;
            case (ph)
              PH_LEAD: begin
                if (section_done()) begin
                  reset_cnt = '0;
                  led_pos   = '0;
                  bit_pos   = '0;
                  ph        = (eff_count() == 0) ? PH_TRAIL : PH_DATA;
                end else begin
                  reset_cnt++;
                end
              end
              PH_DATA: begin
                bit_pos++;
                if (bit_pos >= BitsPerLed) begin
                  bit_pos = '0;
                  led_pos++;
                  if (led_pos >= eff_count()) begin
                    reset_cnt = '0;
                    ph        = PH_TRAIL;
                  end
                end
              end
              default: begin
                if (section_done()) begin
                  reset_cnt    = '0;
                  ph           = PH_IDLE;
                  r.frame_done = 1'b1;
                  frames++;
                end else begin
                  reset_cnt++;
                end
              end
            endcase
          end else begin
            tick_cnt++;
          end
        end
        CMD_WRITE: if (idx < eff_count()) begin
          colours[idx] = {d[15:8], d[23:16], d[31:24]};
          r.accepted   = 1'b1;
          writes_stored++;
        end
        CMD_START: if (ph == PH_IDLE) begin
          ph         = PH_LEAD;
          led_pos    = '0;
          bit_pos    = '0;
          tick_cnt   = '0;
          reset_cnt  = '0;
          r.accepted = 1'b1;
          starts_taken++;
        end
        default: ;
      endcase
      r.busy = (ph != PH_IDLE);
      pending_results.push_back(r);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void compare(string field, logic [3:0] want, logic [3:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(logic [OutDataW-1:0] d);
      result_t want, got;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: result item %0h with nothing expected, expected none, got %0h",
                   $time, d, d);
        return;
      end
      want = pending_results.pop_front();
      got  = d[3:0];
      checked++;
      compare("line_level", want.line_level, got.line_level);
      compare("busy_res", want.busy, got.busy);
      compare("accepted", want.accepted, got.accepted);
      compare("frame_done", want.frame_done, got.frame_done);
      compare("padding", 4'h0, d[7:4]);
    endfunction
  endclass

  strip_scoreboard sb = new();

  always #10 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Run stopped by watchdog after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: check each accepted item, then pick the next ready level
  initial begin
    int gap;
    gap = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 13) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [InDataW-1:0] item(cmd_e k, logic [IndexW-1:0] idx,
                                              logic [7:0] red, logic [7:0] green,
                                              logic [7:0] blue);
    return {blue, green, red, idx, k};
  endfunction

  // Mostly ticks; writes lean towards low indexes so small strips get colours
  function automatic logic [InDataW-1:0] random_item();
    logic [InDataW-1:0] d;
    int unsigned        pick;
    d    = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 78) begin
      d[1:0] = CMD_TICK;
    end else if (pick < 90) begin
      d[1:0] = CMD_WRITE;
      if ($urandom_range(0, 1)) d[7:2] = IndexW'($urandom_range(0, 3));
    end else if (pick < 96) begin
      d[1:0] = CMD_START;
    end else begin
      d[1:0] = CMD_NOP;
    end
    return d;
  endfunction

  function automatic cfg_t pick_config(int p);
    cfg_t c;
    if (p == 1) begin
      c = '1;
    end else if (p == 2) begin
      c = '0;
    end else begin
      c.period_last   = TickW'($urandom_range(0, 7));
      c.one_high      = TickW'($urandom_range(0, 10));
      c.zero_high     = TickW'($urandom_range(0, 10));
      c.reset_periods = ResetW'($urandom_range(0, 3));
      c.lsb_first     = 1'($urandom_range(0, 1));
      if (p == 3)
        c.led_count = CountW'(MaxLeds);
      else if ($urandom_range(0, 5) == 0)
        c.led_count = CountW'($urandom_range(0, 127));
      else
        c.led_count = CountW'($urandom_range(1, 3));
    end
    return c;
  endfunction

  task automatic send_item(input logic [InDataW-1:0] d);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.take_item(d);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic load_config(input cfg_t c);
    put_reg(CFG_PERIOD_LAST, c.period_last);
    put_reg(CFG_ONE_HIGH, c.one_high);
    put_reg(CFG_ZERO_HIGH, c.zero_high);
    put_reg(CFG_RESET_PER, c.reset_periods);
    put_reg(CFG_LSB_FIRST, c.lsb_first);
    put_reg(CFG_LED_COUNT, c.led_count);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  // Stimulus
  initial begin
    cfg_t c;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_on = 1'b1;

    // Reset settings: no-op, idle tick, writes in and out of range, start and
    // a refused start, activity while busy
    send_item(item(CMD_NOP, '1, 8'hff, 8'hff, 8'hff));
    send_item(item(CMD_TICK, '0, 8'h00, 8'h00, 8'h00));
    send_item(item(CMD_WRITE, 6'd0, 8'hff, 8'hff, 8'hff));
    send_item(item(CMD_WRITE, 6'd3, 8'h81, 8'h42, 8'h18));
    send_item(item(CMD_WRITE, 6'd4, 8'h55, 8'haa, 8'h55));
    send_item(item(CMD_WRITE, 6'd63, 8'haa, 8'h55, 8'haa));
    send_item(item(CMD_START, '0, 8'h00, 8'h00, 8'h00));
    send_item(item(CMD_START, '1, 8'hff, 8'hff, 8'hff));
    send_item(item(CMD_NOP, '0, 8'h00, 8'h00, 8'h00));
    send_item(item(CMD_WRITE, 6'd1, 8'h00, 8'hff, 8'h0f));
    repeat (3) send_item(item(CMD_TICK, '1, 8'hff, 8'hff, 8'hff));

    // Period cut short mid-period, no reset periods and an empty strip:
    // the frame runs lead, trailing reset and ends
    drain();
    c.period_last   = 16'd3;
    c.one_high      = 16'hffff;
    c.zero_high     = 16'd0;
    c.reset_periods = 10'd0;
    c.lsb_first     = 1'b0;
    c.led_count     = 7'd0;
    load_config(c);
    repeat (6) send_item(item(CMD_TICK, '0, 8'h00, 8'h00, 8'h00));
    send_item(item(CMD_WRITE, 6'd0, 8'h12, 8'h34, 8'h56));
    send_item(item(CMD_START, '0, 8'h00, 8'h00, 8'h00));

    // Random phases, each under fresh settings written while nothing is in flight
    for (int p = 0; p < NumPhases; p++) begin
      drain();
      load_config(pick_config(p));
      idle_on = (p < 7) && (p != 4);
      if (p == 5) hold_cycles = 300;
      repeat ((p == 1) ? 40 : 105) send_item(random_item());
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d items: %0d colour writes stored, %0d frames started, %0d completed.",
             sb.checked, sb.writes_stored, sb.starts_taken, sb.frames);
    $display("Settings loaded %0d times, including all-max and all-zero registers.",
             settings);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
